@@ src/rws_pkg.sv @@
// Package for the roulette wheel selector: sizes, opcodes, status codes
// and the request and result structures. No dependencies.
package rws_pkg;

   localparam int MAX_ENTRIES   = 64;
   localparam int FITNESS_BITS  = 32;
   localparam int FRACTION_BITS = 16;
   localparam int INDEX_BITS    = $clog2(MAX_ENTRIES);
   localparam int COUNT_BITS    = INDEX_BITS + 1;
   localparam int SUM_BITS      = FITNESS_BITS + INDEX_BITS;
   // The scaling multiply is split at this many bits of the total.
   localparam int MUL_A_BITS    = 32;
   localparam int HIGH_BITS     = SUM_BITS - MUL_A_BITS;
   localparam int PROD_BITS     = MUL_A_BITS + FRACTION_BITS;

   localparam logic [1:0] OP_LOAD   = 2'd0;
   localparam logic [1:0] OP_CLEAR  = 2'd1;
   localparam logic [1:0] OP_SELECT = 2'd2;

   localparam logic [1:0] ST_DONE     = 2'd0;
   localparam logic [1:0] ST_SELECTED = 2'd1;
   localparam logic [1:0] ST_EMPTY    = 2'd2;
   localparam logic [1:0] ST_FULL     = 2'd3;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [31:0] fitness_value;
      logic [15:0] random_fraction;
   } req_type;

   typedef struct packed {
      logic [1:0] status;
      logic [5:0] chosen_index;
      logic [6:0] entry_count;
   } rsp_type;

endpackage

@@ src/rws_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module rws_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ src/rws_scaler.sv @@
// Scales the total fitness by the random fraction over two passes through
// one shared 32 x FRACTION_BITS multiplier. Depends on rws_pkg.
module rws_scaler import rws_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [SUM_BITS-1:0]      total,
   input  logic [FRACTION_BITS-1:0] fraction,
   output logic                     done,
   output logic [SUM_BITS-1:0]      target
);

   logic [1:0]                   step_ff, step_in;
   logic                         done_ff, done_in;
   logic [SUM_BITS-1:0]          total_ff;
   logic [FRACTION_BITS-1:0]     frac_ff;
   logic [MUL_A_BITS-1:0]        lo_part_ff;
   logic [SUM_BITS-1:0]          target_ff;
   logic [MUL_A_BITS-1:0]        mul_a;
   logic [PROD_BITS-1:0]         product;

   // First pass multiplies the low word of the total, second pass the high bits.
   assign mul_a   = (step_ff == 2'd2) ? MUL_A_BITS'(total_ff[SUM_BITS-1:MUL_A_BITS])
                                      : total_ff[MUL_A_BITS-1:0];
   assign product = PROD_BITS'(mul_a) * PROD_BITS'(frac_ff);

   always_comb begin
      step_in = step_ff;
      done_in = 1'b0;
      case (step_ff)
         2'd0: if (start) step_in = 2'd1;
         2'd1: step_in = 2'd2;
         2'd2: begin
            step_in = 2'd0;
            done_in = 1'b1;
         end
         default: step_in = 2'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= 2'd0;
         done_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step_ff == 2'd0 && start) begin
         total_ff <= total;
         frac_ff  <= fraction;
      end
      if (step_ff == 2'd1) begin
         lo_part_ff <= product[PROD_BITS-1:FRACTION_BITS];
      end
      if (step_ff == 2'd2) begin
         target_ff <= {product[HIGH_BITS+FRACTION_BITS-1:0], FRACTION_BITS'(0)}
                      + SUM_BITS'(lo_part_ff);
      end
   end

   assign done   = done_ff;
   assign target = target_ff;

endmodule

@@ src/roulette_wheel_selector.sv @@
// Load and clear requests: result strobed in the cycle after acceptance; a new
// request may be taken in that same cycle. Select: the scaling multiply, then
// binary-search probes, each a RAM read state followed by a compare state;
// busy meanwhile. Synchronous reset empties the table (count and total to
// zero); the RAM is not cleared. Results cannot be stalled by the receiver.
module roulette_wheel_selector import rws_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_item,
   output logic    rsp_strobe,
   output rsp_type rsp_item
);

   localparam logic [1:0] S_IDLE    = 2'd0;
   localparam logic [1:0] S_SCALE   = 2'd1;
   localparam logic [1:0] S_READ    = 2'd2;
   localparam logic [1:0] S_COMPARE = 2'd3;

   logic [1:0]            state_ff, state_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic [SUM_BITS-1:0]   total_ff, total_in;
   logic [INDEX_BITS-1:0] lo_ff, lo_in;
   logic [INDEX_BITS-1:0] hi_ff, hi_in;
   logic                  strobe_ff, strobe_in;
   rsp_type               rsp_ff, rsp_in;

   logic                  accept;
   logic [SUM_BITS-1:0]   load_sum;
   logic                  wr_en;
   logic [INDEX_BITS-1:0] mid;
   logic [SUM_BITS-1:0]   rd_data;
   logic                  scale_start;
   logic                  scale_done;
   logic [SUM_BITS-1:0]   target;

   assign accept   = start && (state_ff == S_IDLE);
   assign load_sum = total_ff + SUM_BITS'(req_item.fitness_value[FITNESS_BITS-1:0]);
   assign wr_en    = accept && (req_item.opcode == OP_LOAD)
                     && (count_ff < COUNT_BITS'(MAX_ENTRIES));
   assign mid      = INDEX_BITS'(({1'b0, lo_ff} + {1'b0, hi_ff}) >> 1);
   assign scale_start = accept && (req_item.opcode == OP_SELECT)
                        && (count_ff != '0) && (total_ff != '0);

   rws_ram #(
      .WIDTH(SUM_BITS),
      .DEPTH(MAX_ENTRIES)
   ) u_sums (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(count_ff[INDEX_BITS-1:0]),
      .wr_data(load_sum),
      .rd_addr(mid),
      .rd_data(rd_data)
   );

   rws_scaler u_scaler (
      .clock   (clock),
      .reset   (reset),
      .start   (scale_start),
      .total   (total_ff),
      .fraction(req_item.random_fraction[FRACTION_BITS-1:0]),
      .done    (scale_done),
      .target  (target)
   );

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      total_in  = total_ff;
      lo_in     = lo_ff;
      hi_in     = hi_ff;
      strobe_in = 1'b0;
      rsp_in    = rsp_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               rsp_in.status       = ST_DONE;
               rsp_in.chosen_index = '0;
               strobe_in           = 1'b1;
               case (req_item.opcode)
                  OP_LOAD: begin
                     if (wr_en) begin
                        total_in = load_sum;
                        count_in = count_ff + 1'b1;
                     end else begin
                        rsp_in.status = ST_FULL;
                     end
                  end
                  OP_CLEAR: begin
                     count_in = '0;
                     total_in = '0;
                  end
                  OP_SELECT: begin
                     if (scale_start) begin
                        strobe_in = 1'b0;
                        lo_in     = '0;
                        hi_in     = INDEX_BITS'(count_ff - 1'b1);
                        state_in  = S_SCALE;
                     end else begin
                        rsp_in.status = ST_EMPTY;
                     end
                  end
                  default: ;
               endcase
               rsp_in.entry_count = count_in;
            end
         end
         S_SCALE: begin
            if (scale_done) begin
               if (lo_ff < hi_ff) begin
                  state_in = S_READ;
               end else begin
                  state_in            = S_IDLE;
                  strobe_in           = 1'b1;
                  rsp_in.status       = ST_SELECTED;
                  rsp_in.chosen_index = lo_ff;
               end
            end
         end
         S_READ: state_in = S_COMPARE;
         S_COMPARE: begin
            if (rd_data > target) begin
               hi_in = mid;
            end else begin
               lo_in = mid + 1'b1;
            end
            if (lo_in < hi_in) begin
               state_in = S_READ;
            end else begin
               state_in            = S_IDLE;
               strobe_in           = 1'b1;
               rsp_in.status       = ST_SELECTED;
               rsp_in.chosen_index = lo_in;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         count_ff  <= '0;
         total_ff  <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         total_ff  <= total_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff  <= lo_in;
      hi_ff  <= hi_in;
      rsp_ff <= rsp_in;
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = strobe_ff;
   assign rsp_item   = rsp_ff;

endmodule

@@ src/rws_checker.sv @@
// Port-level checks for the roulette wheel selector, bound to the top level.
// Depends on rws_pkg.
module rws_checker import rws_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input req_type req_item,
   input logic    rsp_strobe,
   input rsp_type rsp_item
);

   // A clear empties the table and reports an empty table with status done.
   assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_item.opcode == OP_CLEAR
      |=> rsp_strobe && rsp_item.entry_count == '0 && rsp_item.status == ST_DONE)
      else $error("clear request did not report an empty table");

   // Loads are answered in the following cycle.
   assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_item.opcode == OP_LOAD |=> rsp_strobe)
      else $error("load request not answered in the next cycle");

   // A chosen individual always lies inside the table.
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_item.status == ST_SELECTED
      |-> COUNT_BITS'(rsp_item.chosen_index) < rsp_item.entry_count)
      else $error("chosen index beyond the number of entries");

   // The entry count never exceeds the table size.
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> rsp_item.entry_count <= COUNT_BITS'(MAX_ENTRIES))
      else $error("entry count above table size");

   // Results other than a selection carry index zero.
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_item.status != ST_SELECTED |-> rsp_item.chosen_index == '0)
      else $error("non-select result with a nonzero index");

endmodule

bind roulette_wheel_selector rws_checker u_rws_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .req_item  (req_item),
   .rsp_strobe(rsp_strobe),
   .rsp_item  (rsp_item)
);

@@ test/testbench.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for roulette_wheel_selector: directed and random
// requests, with a built-in prediction of each result. Depends on rws_pkg.
module testbench;
   import rws_pkg::*;

   localparam int CYCLE_LIMIT = 500000;
   localparam int DRAIN_CYCLES = 24;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_item = '0;
   logic    rsp_strobe;
   rsp_type rsp_item;

   // Predicted contents of the selector: running sums, entry count and total.
   logic [SUM_BITS-1:0]   wheel_sums [MAX_ENTRIES];
   logic [COUNT_BITS-1:0] wheel_count = '0;
   logic [SUM_BITS-1:0]   wheel_total = '0;

   rsp_type pending_results [$];
   int      error_count = 0;
   int      accepted_count = 0;
   int      cycle_count = 0;

   roulette_wheel_selector u_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("RESULT: ERROR");
         $finish;
      end
   end

   task automatic report_mismatch(input string what, input longint got, input longint want);
      if (error_count < 50)
         $display("mismatch in %s: got %0d, expected %0d (cycle %0d)",
                  what, got, want, cycle_count);
      error_count++;
   endtask

   // Applies one request to the predicted state and returns its result.
   function automatic rsp_type spin_wheel(input req_type item);
      rsp_type     outcome;
      logic [63:0] target;
      int          pick;
      outcome = '0;
      outcome.status = ST_DONE;
      case (item.opcode)
         OP_LOAD: begin
            if (wheel_count >= MAX_ENTRIES) begin
               outcome.status = ST_FULL;
            end else begin
               wheel_total = wheel_total + SUM_BITS'(item.fitness_value);
               wheel_sums[wheel_count] = wheel_total;
               wheel_count = wheel_count + 1'b1;
            end
         end
         OP_CLEAR: begin
            wheel_count = '0;
            wheel_total = '0;
         end
         OP_SELECT: begin
            if (wheel_count == 0 || wheel_total == 0) begin
               outcome.status = ST_EMPTY;
            end else begin
               target = (64'(wheel_total) * 64'(item.random_fraction)) >> FRACTION_BITS;
               // The first entry whose running sum exceeds the target wins;
               // the last entry is the fallback.
               pick = int'(wheel_count) - 1;
               for (int i = int'(wheel_count) - 1; i >= 0; i--)
                  if (64'(wheel_sums[i]) > target)
                     pick = i;
               outcome.status = ST_SELECTED;
               outcome.chosen_index = pick[INDEX_BITS-1:0];
            end
         end
         default: ;
      endcase
      outcome.entry_count = wheel_count;
      return outcome;
   endfunction

   // Holds the request on the port until it is taken; start stays high after.
   task automatic send_request(input req_type item);
      rsp_type predicted;
      req_item <= item;
      start <= 1'b1;
      forever begin
         @(posedge clock);
         if (!busy)
            break;
      end
      predicted = spin_wheel(item);
      pending_results = {pending_results, predicted};
      accepted_count++;
   endtask

   task automatic hold_off(input int cycles);
      start <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic wait_for_results;
      start <= 1'b0;
      while (pending_results.size() != 0)
         @(posedge clock);
   endtask

   task automatic issue(input logic [1:0] opcode, input logic [31:0] fitness,
                        input logic [15:0] fraction, input int idle_pct);
      req_type item;
      item.opcode = opcode;
      item.fitness_value = fitness;
      item.random_fraction = fraction;
      if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct)
         hold_off($urandom_range(1, 12));
      send_request(item);
   endtask

   function automatic logic [31:0] random_fitness;
      case ($urandom_range(0, 5))
         0: return 32'd0;
         1: return 32'hFFFF_FFFF;
         2: return 32'($urandom_range(1, 100));
         default: return 32'($urandom);
      endcase
   endfunction

   function automatic logic [15:0] random_fraction;
      case ($urandom_range(0, 7))
         0: return 16'h0000;
         1: return 16'hFFFF;
         default: return 16'($urandom_range(0, 65535));
      endcase
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_strobe) begin
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected result", longint'(rsp_item), longint'(0));
         end else begin
            want = pending_results.pop_front();
            if (rsp_item.status !== want.status)
               report_mismatch("status", longint'(rsp_item.status),
                               longint'(want.status));
            if (rsp_item.chosen_index !== want.chosen_index)
               report_mismatch("chosen_index", longint'(rsp_item.chosen_index),
                               longint'(want.chosen_index));
            if (rsp_item.entry_count !== want.entry_count)
               report_mismatch("entry_count", longint'(rsp_item.entry_count),
                               longint'(want.entry_count));
         end
      end
   end

   task automatic test_empty_table;
      issue(OP_SELECT, 32'd0, 16'h0000, 0);
      issue(OP_CLEAR, 32'hFFFF_FFFF, 16'hFFFF, 0);
      issue(OP_SELECT, 32'd0, 16'hFFFF, 0);
      issue(2'd3, 32'hFFFF_FFFF, 16'hFFFF, 0);
   endtask

   task automatic test_zero_total;
      issue(OP_LOAD, 32'd0, 16'h0000, 0);
      issue(OP_LOAD, 32'd0, 16'hFFFF, 0);
      issue(OP_SELECT, 32'd0, 16'h8000, 0);
      issue(OP_CLEAR, 32'd0, 16'h0000, 0);
   endtask

   task automatic test_extreme_fitness;
      issue(OP_LOAD, 32'hFFFF_FFFF, 16'h0000, 0);
      issue(OP_LOAD, 32'd0, 16'h0000, 0);
      issue(OP_LOAD, 32'hFFFF_FFFF, 16'h0000, 0);
      issue(OP_LOAD, 32'd1, 16'h0000, 0);
      issue(OP_SELECT, 32'd0, 16'h0000, 0);
      issue(OP_SELECT, 32'd0, 16'hFFFF, 0);
      issue(OP_SELECT, 32'hFFFF_FFFF, 16'h8000, 0);
      issue(2'd3, 32'h5A5A_A5A5, 16'h1234, 0);
      issue(OP_CLEAR, 32'd0, 16'h0000, 0);
   endtask

   // Entries of zero weight must never be picked, whatever the fraction.
   task automatic test_zero_weight_entries;
      issue(OP_LOAD, 32'd0, 16'h0000, 0);
      issue(OP_LOAD, 32'd5, 16'h0000, 0);
      issue(OP_LOAD, 32'd0, 16'h0000, 0);
      issue(OP_SELECT, 32'd0, 16'h0000, 0);
      issue(OP_SELECT, 32'd0, 16'hFFFF, 0);
   endtask

   // Mostly well-formed sessions (clear, loads, selects), sometimes running
   // past a full table, mixed with stray requests of any opcode.
   task automatic test_random_sessions(input int request_target, input int idle_pct);
      int first;
      int loads;
      int picks;
      first = accepted_count;
      while (accepted_count - first < request_target) begin
         if ($urandom_range(0, 99) < 70) begin
            if ($urandom_range(0, 1) == 0)
               issue(OP_CLEAR, random_fitness(), random_fraction(), idle_pct);
            loads = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 12);
            picks = $urandom_range(1, 8);
            repeat (loads) issue(OP_LOAD, random_fitness(), random_fraction(), idle_pct);
            repeat (picks) issue(OP_SELECT, random_fitness(), random_fraction(), idle_pct);
         end else begin
            repeat ($urandom_range(1, 4))
               issue(2'($urandom_range(0, 3)), random_fitness(), random_fraction(), idle_pct);
         end
         if ($urandom_range(0, 19) == 0)
            wait_for_results();
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_empty_table();
      test_zero_total();
      test_extreme_fitness();
      test_zero_weight_entries();
      wait_for_results();
      test_random_sessions(620, 16);
      test_random_sessions(620, 80);
      test_random_sessions(620, 0);
      start <= 1'b0;
      while (pending_results.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
